/* hw/rtl/hwsd_pkg.sv */
// ----------------------------------------------------------------------------
// hwsd_pkg: shared types and constants of the hall wheel scroll decoder
// register indexes, reset values, motion and direction codes
// ----------------------------------------------------------------------------
`default_nettype none

package hwsd_pkg;

   // default widths
   localparam int ADC_BITS_DEF  = 10;
   localparam int TIME_BITS_DEF = 16;
   localparam int BAND_BITS     = 8;

   // configuration register indexes
   localparam int CSR_ADDR_BITS = 3;
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_MAG_HIGH          = 3'd0,
      CSR_MAG_LOW           = 3'd1,
      CSR_MOVE_BAND         = 3'd2,
      CSR_BUTTON_HOLDOFF_MS = 3'd3,
      CSR_FLIP_WINDOW_MS    = 3'd4,
      CSR_SCROLL_WHILE_HELD = 3'd5
   } csr_index_type;

   // register reset values
   localparam int MAG_HIGH_RST          = 680;
   localparam int MAG_LOW_RST           = 400;
   localparam int MOVE_BAND_RST         = 3;
   localparam int BUTTON_HOLDOFF_MS_RST = 100;
   localparam int FLIP_WINDOW_MS_RST    = 150;

   // item kinds carried in tuser
   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_BUTTON = 1'b1
   } cmd_type;

   // per-channel motion against the stored reference
   typedef enum logic [1:0] {
      MOTION_STILL   = 2'd0,
      MOTION_RISING  = 2'd1,
      MOTION_FALLING = 2'd2
   } motion_type;

   // wheel direction of a crossing or a tick
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

endpackage

`default_nettype wire

/* hw/rtl/hall_wheel_scroll_decoder.sv */
// ----------------------------------------------------------------------------
// hall_wheel_scroll_decoder: scroll wheel decoder for two analog hall sensors
// turns sensor samples and middle-button beats into up/down wheel ticks
// ----------------------------------------------------------------------------
// The block takes one beat per clock and gives at most one tick per beat.
// A request beat is captured in an input register; the decode logic
// (dead-band compares, pole-level compares and the two time windows) then
// runs against the wheel state and loads the tick into the result
// register, which drives rsp_tvalid. The sustained rate is one beat per
// cycle. The pipe stalls only while a tick waits in the result register
// and rsp_tready is low. Only every other sample beat is decoded; samples
// are dropped during the button holdoff and while the middle button is
// held unless scroll_while_held is set.
// Configuration writes take effect at the next edge and belong to idle time.
`default_nettype none

module hall_wheel_scroll_decoder #(
   parameter int ADC_BITS  = hwsd_pkg::ADC_BITS_DEF,
   parameter int TIME_BITS = hwsd_pkg::TIME_BITS_DEF,
   localparam int REQ_BITS   = 2*ADC_BITS + TIME_BITS + 1,
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8,
   localparam int CSR_DATA_W = (ADC_BITS > TIME_BITS) ? ADC_BITS : TIME_BITS
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // request channel
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // sensor_a, sensor_b, now_ms, button_down (lowest bit first)
   input  wire  [REQ_DATA_W-1:0]                 req_tdata,
   // cmd
   input  wire                                   req_tuser,
   // result channel
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // scroll_up
   output logic [7:0]                            rsp_tdata,
   // configuration port
   input  wire                                   csr_we,
   input  wire  [hwsd_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  wire  [CSR_DATA_W-1:0]                 csr_wdata
);

   localparam int SUM_W = ADC_BITS + 1;

   // request field positions
   localparam int A_LO   = 0;
   localparam int B_LO   = ADC_BITS;
   localparam int T_LO   = 2*ADC_BITS;
   localparam int BTN_AT = 2*ADC_BITS + TIME_BITS;

   // configuration registers
   logic [ADC_BITS-1:0]             mag_high_ff, mag_low_ff;
   logic [hwsd_pkg::BAND_BITS-1:0]  move_band_ff;
   logic [TIME_BITS-1:0]            holdoff_ff, flip_window_ff;
   logic                            scroll_while_held_ff;

   // input register
   logic                            in_valid_ff;
   hwsd_pkg::cmd_type               in_cmd_ff;
   logic [ADC_BITS-1:0]             in_a_ff, in_b_ff;
   logic [TIME_BITS-1:0]            in_now_ff;
   logic                            in_btn_ff;

   // wheel state
   logic                            phase_ff, phase_in;
   logic [TIME_BITS-1:0]            button_time_ff, button_time_in;
   logic                            button_held_ff, button_held_in;
   hwsd_pkg::dir_type               crossing_dir_ff, crossing_dir_in;
   hwsd_pkg::dir_type               last_tick_dir_ff, last_tick_dir_in;
   logic [TIME_BITS-1:0]            last_tick_time_ff, last_tick_time_in;
   logic [ADC_BITS-1:0]             ref_a_ff, ref_a_in, ref_b_ff, ref_b_in;
   hwsd_pkg::motion_type            motion_last_ff, motion_last_in;
   hwsd_pkg::motion_type            motion_prev_ff, motion_prev_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_up_ff, rsp_up_in;

   logic                            out_free, fire, evaluate, emit;
   logic [TIME_BITS-1:0]            since_button, since_tick;
   logic [SUM_W-1:0]                a_w, b_w, ra_w, rb_w, band_w;
   hwsd_pkg::motion_type            ma, mb;
   logic                            above_high, below_low;
   hwsd_pkg::dir_type               new_dir;

   // handshake: the pipe moves unless a tick waits downstream
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_up_ff};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mag_high_ff          <= ADC_BITS'(hwsd_pkg::MAG_HIGH_RST);
         mag_low_ff           <= ADC_BITS'(hwsd_pkg::MAG_LOW_RST);
         move_band_ff         <= hwsd_pkg::BAND_BITS'(hwsd_pkg::MOVE_BAND_RST);
         holdoff_ff           <= TIME_BITS'(hwsd_pkg::BUTTON_HOLDOFF_MS_RST);
         flip_window_ff       <= TIME_BITS'(hwsd_pkg::FLIP_WINDOW_MS_RST);
         scroll_while_held_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            hwsd_pkg::CSR_MAG_HIGH:          mag_high_ff    <= csr_wdata[ADC_BITS-1:0];
            hwsd_pkg::CSR_MAG_LOW:           mag_low_ff     <= csr_wdata[ADC_BITS-1:0];
            hwsd_pkg::CSR_MOVE_BAND:
               move_band_ff <= csr_wdata[hwsd_pkg::BAND_BITS-1:0];
            hwsd_pkg::CSR_BUTTON_HOLDOFF_MS: holdoff_ff     <= csr_wdata[TIME_BITS-1:0];
            hwsd_pkg::CSR_FLIP_WINDOW_MS:    flip_window_ff <= csr_wdata[TIME_BITS-1:0];
            hwsd_pkg::CSR_SCROLL_WHILE_HELD: scroll_while_held_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_cmd_ff <= hwsd_pkg::cmd_type'(req_tuser);
         in_a_ff   <= req_tdata[A_LO +: ADC_BITS];
         in_b_ff   <= req_tdata[B_LO +: ADC_BITS];
         in_now_ff <= req_tdata[T_LO +: TIME_BITS];
         in_btn_ff <= req_tdata[BTN_AT];
      end
   end

   // elapsed times wrap with the millisecond counter
   assign since_button = in_now_ff - button_time_ff;
   assign since_tick   = in_now_ff - last_tick_time_ff;

   // a sample is decoded on the even phase, outside holdoff and, unless scroll_while_held is set, outside hold
   assign evaluate = fire && (in_cmd_ff == hwsd_pkg::CMD_SAMPLE) && !phase_ff
                     && (since_button >= holdoff_ff)
                     && !(button_held_ff && !scroll_while_held_ff);

   // dead-band motion of each channel
   assign a_w    = {1'b0, in_a_ff};
   assign b_w    = {1'b0, in_b_ff};
   assign ra_w   = {1'b0, ref_a_ff};
   assign rb_w   = {1'b0, ref_b_ff};
   assign band_w = SUM_W'(move_band_ff);

   always_comb begin
      if (a_w > ra_w + band_w)       ma = hwsd_pkg::MOTION_RISING;
      else if (a_w + band_w < ra_w)  ma = hwsd_pkg::MOTION_FALLING;
      else                           ma = hwsd_pkg::MOTION_STILL;
      if (b_w > rb_w + band_w)       mb = hwsd_pkg::MOTION_RISING;
      else if (b_w + band_w < rb_w)  mb = hwsd_pkg::MOTION_FALLING;
      else                           mb = hwsd_pkg::MOTION_STILL;
   end

   // pole levels and the direction a fresh crossing gives
   assign above_high = in_a_ff > mag_high_ff;
   assign below_low  = in_a_ff < mag_low_ff;

   always_comb begin
      new_dir = hwsd_pkg::DIR_NONE;
      if (motion_last_ff != ma && motion_prev_ff != ma) begin
         priority if ((above_high && mb == hwsd_pkg::MOTION_FALLING) ||
                      (below_low  && mb == hwsd_pkg::MOTION_RISING)) begin
            new_dir = hwsd_pkg::DIR_UP;
         end else if ((above_high && mb == hwsd_pkg::MOTION_RISING) ||
                      (below_low  && mb == hwsd_pkg::MOTION_FALLING)) begin
            new_dir = hwsd_pkg::DIR_DOWN;
         end else begin
            new_dir = hwsd_pkg::DIR_NONE;
         end
      end
   end

   // next wheel state and tick
   always_comb begin
      phase_in          = phase_ff;
      button_time_in    = button_time_ff;
      button_held_in    = button_held_ff;
      crossing_dir_in   = crossing_dir_ff;
      last_tick_dir_in  = last_tick_dir_ff;
      last_tick_time_in = last_tick_time_ff;
      ref_a_in          = ref_a_ff;
      ref_b_in          = ref_b_ff;
      motion_last_in    = motion_last_ff;
      motion_prev_in    = motion_prev_ff;
      emit              = 1'b0;
      rsp_up_in         = rsp_up_ff;

      if (fire) begin
         if (in_cmd_ff == hwsd_pkg::CMD_BUTTON) begin
            button_time_in = in_now_ff;
            button_held_in = in_btn_ff;
         end else begin
            phase_in = !phase_ff;
         end
      end

      if (evaluate) begin
         // crossing detection, or rearm once A is back inside the level
         if (crossing_dir_ff == hwsd_pkg::DIR_NONE && (above_high || below_low)) begin
            if (new_dir != hwsd_pkg::DIR_NONE) begin
               crossing_dir_in = new_dir;
               // a quick reversal keeps the last tick direction
               if (since_tick < flip_window_ff && last_tick_dir_ff != hwsd_pkg::DIR_NONE)
                  crossing_dir_in = last_tick_dir_ff;
               emit              = 1'b1;
               rsp_up_in         = (crossing_dir_in == hwsd_pkg::DIR_UP);
               last_tick_time_in = in_now_ff;
               last_tick_dir_in  = crossing_dir_in;
            end
         end else if ((crossing_dir_ff == hwsd_pkg::DIR_UP   && in_a_ff < mag_high_ff) ||
                      (crossing_dir_ff == hwsd_pkg::DIR_DOWN && in_a_ff > mag_low_ff)) begin
            crossing_dir_in = hwsd_pkg::DIR_NONE;
         end

         // references follow any motion beyond the dead band
         if (ma != hwsd_pkg::MOTION_STILL || mb != hwsd_pkg::MOTION_STILL) begin
            motion_prev_in = motion_last_ff;
            motion_last_in = ma;
            ref_a_in       = in_a_ff;
            ref_b_in       = in_b_ff;
         end
      end

      // result register holds a tick until taken
      if (emit)            rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   // wheel state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= 1'b0;
         button_time_ff    <= '0;
         button_held_ff    <= 1'b0;
         crossing_dir_ff   <= hwsd_pkg::DIR_NONE;
         last_tick_dir_ff  <= hwsd_pkg::DIR_NONE;
         last_tick_time_ff <= '0;
         ref_a_ff          <= '0;
         ref_b_ff          <= '0;
         motion_last_ff    <= hwsd_pkg::MOTION_STILL;
         motion_prev_ff    <= hwsd_pkg::MOTION_STILL;
         rsp_valid_ff      <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         button_time_ff    <= button_time_in;
         button_held_ff    <= button_held_in;
         crossing_dir_ff   <= crossing_dir_in;
         last_tick_dir_ff  <= last_tick_dir_in;
         last_tick_time_ff <= last_tick_time_in;
         ref_a_ff          <= ref_a_in;
         ref_b_ff          <= ref_b_in;
         motion_last_ff    <= motion_last_in;
         motion_prev_ff    <= motion_prev_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      rsp_up_ff <= rsp_up_in;
   end

endmodule

`default_nettype wire
